/* sv/iso9660_directory_record_scanner_assert.svh */
// ---------------------------------------------------------------------------
// Directory record scanner assertion macros
// Clocked property checks used by the scanner top level.
// ---------------------------------------------------------------------------
`ifndef ISO9660_DIRECTORY_RECORD_SCANNER_ASSERT_SVH
`define ISO9660_DIRECTORY_RECORD_SCANNER_ASSERT_SVH

// Check that an expression holds at every clock edge outside reset.
`define ISODIR_CHECK(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("isodir: check failed");

// Check that a condition implies an expression in the same cycle.
`define ISODIR_CHECK_IMPL(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("isodir: implication failed");

`endif

/* sv/isodir_pkg.sv */
// ---------------------------------------------------------------------------
// Directory record scanner package
// Types, record layout offsets and sizing constants for the scanner.
// ---------------------------------------------------------------------------
package isodir_pkg;

  localparam int SECTOR_BYTES_DEF = 2048;
  localparam int OFFSET_BITS_DEF  = 24;
  localparam int DIR_SIZE_W       = 24;
  localparam int NAME_OFF_W       = 24;
  localparam int OUTQ_DEPTH       = 4;
  localparam int OUTQ_CNT_W       = $clog2(OUTQ_DEPTH + 1);
  localparam int DATA_OUT_W       = 96;

  localparam logic [7:0] MIN_RECORD   = 8'd33;
  localparam int         DIR_FLAG_BIT = 1;

  // byte positions inside a directory record
  localparam logic [7:0] IDX_LBA_0    = 8'd2;
  localparam logic [7:0] IDX_LBA_1    = 8'd3;
  localparam logic [7:0] IDX_LBA_2    = 8'd4;
  localparam logic [7:0] IDX_LBA_3    = 8'd5;
  localparam logic [7:0] IDX_SIZE_0   = 8'd10;
  localparam logic [7:0] IDX_SIZE_1   = 8'd11;
  localparam logic [7:0] IDX_SIZE_2   = 8'd12;
  localparam logic [7:0] IDX_SIZE_3   = 8'd13;
  localparam logic [7:0] IDX_FLAGS    = 8'd25;
  localparam logic [7:0] IDX_NAME_LEN = 8'd32;
  localparam logic [7:0] IDX_NAME_0   = 8'd33;

  typedef enum logic [1:0] {
    MODE_AWAIT  = 2'd0,
    MODE_RECORD = 2'd1,
    MODE_SKIP   = 2'd2,
    MODE_STOP   = 2'd3
  } scan_mode_t;

  typedef enum logic [1:0] {
    KIND_FILE = 2'd0,
    KIND_DIR  = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic [31:0]             extent_lba;
    logic [31:0]             extent_bytes;
    logic [NAME_OFF_W-1:0]   name_offset;
    logic [7:0]              name_length;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic    valid0;
    logic    valid1;
    result_t r0;
    result_t r1;
  } push_t;

  typedef struct packed {
    logic                  room2;
    logic [OUTQ_CNT_W-1:0] count;
  } outq_status_t;

endpackage

/* sv/isodir_outq.sv */
// ---------------------------------------------------------------------------
// Scanner result queue
// Small register queue: up to two results in a cycle, one out per ready cycle.
// ---------------------------------------------------------------------------
module isodir_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  isodir_pkg::push_t     push,
  output isodir_pkg::result_t   head,
  output logic                  head_valid,
  input  logic                  head_ready,
  output isodir_pkg::outq_status_t status
);
  import isodir_pkg::*;

  localparam int PW = $clog2(OUTQ_DEPTH);

  result_t               entries [OUTQ_DEPTH];
  logic [PW-1:0]         wr_ptr;
  logic [PW-1:0]         rd_ptr;
  logic [OUTQ_CNT_W-1:0] count;
  logic [OUTQ_CNT_W-1:0] count_next;
  logic [1:0]            push_n;
  logic                  pop;

  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign pop        = head_valid && head_ready;
  assign push_n     = {1'b0, push.valid0} + {1'b0, push.valid1};
  assign count_next = count + OUTQ_CNT_W'(push_n) - OUTQ_CNT_W'(pop);

  assign status.count = count;
  assign status.room2 = (count <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.valid0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.valid1) begin
      entries[wr_ptr + PW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count_next;
    end
  end

endmodule

/* sv/isodir_core.sv */
// ---------------------------------------------------------------------------
// Scanner core
// Input byte register, record walk state and result build for one byte.
// ---------------------------------------------------------------------------
module isodir_core #(
  parameter int SECTOR_BYTES = isodir_pkg::SECTOR_BYTES_DEF,
  parameter int OFFSET_BITS  = isodir_pkg::OFFSET_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [isodir_pkg::DIR_SIZE_W-1:0] dir_size,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_byte,
  input  logic                              in_start,
  input  logic                              room2,
  output isodir_pkg::push_t                 push
);
  import isodir_pkg::*;

  localparam int OW  = OFFSET_BITS;
  localparam int CW  = ((OW > DIR_SIZE_W) ? OW : DIR_SIZE_W) + 2;
  localparam int SPW = $clog2(SECTOR_BYTES);

  // input register
  logic       held;
  logic [7:0] byte_q;
  logic       start_q;

  // scan state
  scan_mode_t     mode;
  scan_mode_t     mode_next;
  logic [OW-1:0]  offset;
  logic [OW-1:0]  offset_next;
  logic [SPW-1:0] sec_pos;
  logic [SPW-1:0] sec_pos_next;
  logic [OW-1:0]  sec_base;
  logic [OW-1:0]  sec_base_next;
  logic [OW-1:0]  rec_start;
  logic [CW-1:0]  rec_send;
  logic [7:0]     rec_len;
  logic [7:0]     rec_idx;
  logic [7:0]     rec_idx_next;
  logic [31:0]    lba;
  logic [31:0]    size_acc;
  logic [7:0]     flags;
  logic [7:0]     nlen;
  logic [7:0]     name0;

  // per-byte decode
  logic           step;
  scan_mode_t     eff_mode;
  logic [OW-1:0]  o;
  logic [SPW-1:0] spos;
  logic [OW-1:0]  sbase;
  logic [CW-1:0]  oc;
  logic [CW-1:0]  sz;
  logic [CW-1:0]  next_bnd;
  logic           end_await;
  logic           go_skip;
  logic           new_rec;
  logic           in_rec;
  logic [7:0]     idx;
  logic [7:0]     len;
  logic [OW-1:0]  start_c;
  logic [CW-1:0]  send_c;
  logic [CW-1:0]  send_lim;
  logic [31:0]    lba_n;
  logic [31:0]    size_n;
  logic [7:0]     flags_n;
  logic [7:0]     nlen_n;
  logic [7:0]     name0_n;
  logic           finish;
  logic           keep;
  logic           emit_entry;
  logic           emit_end;
  logic [CW-1:0]  noff_sum;
  result_t        res_entry;
  result_t        res_end;

  assign in_ready = !held || room2;
  assign step     = held && room2;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (step) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q  <= in_byte;
      start_q <= in_start;
    end
  end

  // extent start wipes the offset and restarts the walk
  assign eff_mode = start_q ? MODE_AWAIT : mode;
  assign o        = start_q ? '0 : offset;
  assign spos     = start_q ? '0 : sec_pos;
  assign sbase    = start_q ? '0 : sec_base;
  assign oc       = CW'(o);
  assign sz       = CW'(dir_size);
  assign next_bnd = CW'(sbase) + CW'(SECTOR_BYTES);

  // decode the byte against the current walk
  always_comb begin
    end_await = 1'b0;
    go_skip   = 1'b0;
    new_rec   = 1'b0;
    if (eff_mode == MODE_AWAIT) begin
      if (oc >= sz) begin
        end_await = 1'b1;
      end else if (byte_q == 8'd0) begin
        if (next_bnd >= sz) begin
          end_await = 1'b1;
        end else begin
          go_skip = 1'b1;
        end
      end else if (oc + CW'(byte_q) > sz) begin
        end_await = 1'b1;
      end else begin
        new_rec = 1'b1;
      end
    end

    in_rec  = (eff_mode == MODE_RECORD) || new_rec;
    idx     = new_rec ? 8'd0 : rec_idx;
    len     = new_rec ? byte_q : rec_len;
    start_c = new_rec ? o : rec_start;
    send_c  = new_rec ? next_bnd : rec_send;
    lba_n   = new_rec ? 32'd0 : lba;
    size_n  = new_rec ? 32'd0 : size_acc;
    flags_n = new_rec ? 8'd0 : flags;
    nlen_n  = new_rec ? 8'd0 : nlen;
    name0_n = new_rec ? 8'd0 : name0;

    case (idx)
      IDX_LBA_0:    lba_n[7:0]    = lba_n[7:0]    | byte_q;
      IDX_LBA_1:    lba_n[15:8]   = lba_n[15:8]   | byte_q;
      IDX_LBA_2:    lba_n[23:16]  = lba_n[23:16]  | byte_q;
      IDX_LBA_3:    lba_n[31:24]  = lba_n[31:24]  | byte_q;
      IDX_SIZE_0:   size_n[7:0]   = size_n[7:0]   | byte_q;
      IDX_SIZE_1:   size_n[15:8]  = size_n[15:8]  | byte_q;
      IDX_SIZE_2:   size_n[23:16] = size_n[23:16] | byte_q;
      IDX_SIZE_3:   size_n[31:24] = size_n[31:24] | byte_q;
      IDX_FLAGS:    flags_n       = byte_q;
      IDX_NAME_LEN: nlen_n        = byte_q;
      IDX_NAME_0:   name0_n       = byte_q;
      default:      ;
    endcase

    finish   = in_rec && ({1'b0, idx} + 9'd1 >= {1'b0, len});
    send_lim = (send_c > sz) ? sz : send_c;
    keep     = (len >= MIN_RECORD)
            && !(CW'(start_c) + CW'(len) > send_lim)
            && !({1'b0, MIN_RECORD} + {1'b0, nlen_n} > {1'b0, len})
            // drop the dot and dot-dot entries
            && !(nlen_n == 8'd1 && name0_n <= 8'd1);

    emit_entry = finish && keep;
    emit_end   = end_await || (finish && (oc + CW'(1) >= sz));
  end

  // next walk state
  always_comb begin
    mode_next     = eff_mode;
    offset_next   = o;
    sec_pos_next  = spos;
    sec_base_next = sbase;
    rec_idx_next  = idx + 8'd1;
    if (eff_mode != MODE_STOP) begin
      if (emit_end) begin
        mode_next = MODE_STOP;
      end else if (go_skip) begin
        mode_next = MODE_SKIP;
      end else if (in_rec) begin
        mode_next = finish ? MODE_AWAIT : MODE_RECORD;
      end
      // hold the offset once it saturates
      if (o != {OW{1'b1}}) begin
        offset_next = o + OW'(1);
        if (spos == SPW'(SECTOR_BYTES - 1)) begin
          sec_pos_next  = '0;
          sec_base_next = sbase + OW'(SECTOR_BYTES);
        end else begin
          sec_pos_next = spos + SPW'(1);
        end
      end
      if (mode_next == MODE_SKIP && spos == SPW'(SECTOR_BYTES - 1)) begin
        mode_next = MODE_AWAIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_AWAIT;
      offset   <= '0;
      sec_pos  <= '0;
      sec_base <= '0;
      rec_idx  <= '0;
      rec_len  <= '0;
      rec_start <= '0;
      rec_send <= '0;
      lba      <= '0;
      size_acc <= '0;
      flags    <= '0;
      nlen     <= '0;
      name0    <= '0;
    end else if (step) begin
      mode     <= mode_next;
      offset   <= offset_next;
      sec_pos  <= sec_pos_next;
      sec_base <= sec_base_next;
      if (in_rec) begin
        rec_idx   <= rec_idx_next;
        rec_len   <= len;
        rec_start <= start_c;
        rec_send  <= send_c;
        lba       <= lba_n;
        size_acc  <= size_n;
        flags     <= flags_n;
        nlen      <= nlen_n;
        name0     <= name0_n;
      end
    end
  end

  // result build
  always_comb begin
    noff_sum = CW'(start_c) + CW'(MIN_RECORD);

    res_entry.kind         = flags_n[DIR_FLAG_BIT] ? KIND_DIR : KIND_FILE;
    res_entry.extent_lba   = lba_n;
    res_entry.extent_bytes = size_n;
    res_entry.name_offset  = (noff_sum > CW'({NAME_OFF_W{1'b1}})) ?
                             {NAME_OFF_W{1'b1}} : noff_sum[NAME_OFF_W-1:0];
    res_entry.name_length  = nlen_n;
    res_entry.last         = !emit_end;

    res_end.kind         = KIND_END;
    res_end.extent_lba   = '0;
    res_end.extent_bytes = '0;
    res_end.name_offset  = '0;
    res_end.name_length  = '0;
    res_end.last         = 1'b1;

    push.valid0 = step && (eff_mode != MODE_STOP) && (emit_entry || emit_end);
    push.valid1 = step && (eff_mode != MODE_STOP) && emit_entry && emit_end;
    push.r0     = emit_entry ? res_entry : res_end;
    push.r1     = res_end;
  end

endmodule

/* sv/iso9660_directory_record_scanner.sv */
// ---------------------------------------------------------------------------
// ISO 9660 directory record scanner
// Walks the bytes of a directory extent and reports each usable record.
// Input stream: one extent byte per transfer in s_axis_tdata; s_axis_tuser
// marks the first byte of a new extent and restarts the walk at offset 0.
// cfg_valid/cfg_data write the extent byte length; write it while idle.
// Output stream: one result per transfer; tuser is the kind (file,
// directory, scan ended), tlast marks the final result from one byte.
// Throughput: one byte per cycle while two queue slots are free;
// a byte closing a kept record at the end of the extent gives two results.
// Accepted bytes are held in an input register; results go via the queue.
// A four-entry result queue lets input continue while the receiver stalls;
// the input stalls only when fewer than two queue slots are free.
// Reset clears the walk to offset 0, empties the queue and zeroes dir_size.
// After the scan-ended result, bytes are dropped until the next start.
// ---------------------------------------------------------------------------
`include "iso9660_directory_record_scanner_assert.svh"

module iso9660_directory_record_scanner #(
  parameter int SECTOR_BYTES = isodir_pkg::SECTOR_BYTES_DEF,
  parameter int OFFSET_BITS  = isodir_pkg::OFFSET_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration: dir_size
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [isodir_pkg::DIR_SIZE_W-1:0] cfg_data,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] data_byte
  input  logic                              s_axis_tuser,  // [0] extent_start
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] extent_lba, [63:32] extent_bytes, [87:64] name_offset,
  // [95:88] name_length
  output logic [isodir_pkg::DATA_OUT_W-1:0] m_axis_tdata,
  output logic [1:0]                        m_axis_tuser,  // [1:0] kind
  output logic                              m_axis_tlast
);
  import isodir_pkg::*;

  logic [DIR_SIZE_W-1:0] dir_size;
  push_t                 push;
  result_t               head;
  outq_status_t          q_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_size <= '0;
    end else if (cfg_valid && cfg_ready) begin
      dir_size <= cfg_data;
    end
  end

  isodir_core #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .dir_size (dir_size),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_start (s_axis_tuser),
    .room2    (q_status.room2),
    .push     (push)
  );

  isodir_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .head       (head),
    .head_valid (m_axis_tvalid),
    .head_ready (m_axis_tready),
    .status     (q_status)
  );

  assign m_axis_tdata = {head.name_length, head.name_offset,
                         head.extent_bytes, head.extent_lba};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

  `ISODIR_CHECK(a_queue_bound, clk, rst, q_status.count <= OUTQ_CNT_W'(OUTQ_DEPTH))
  `ISODIR_CHECK_IMPL(a_second_is_end, clk, rst, push.valid1,
    push.valid0 && push.r1.kind == KIND_END && push.r1.last && !push.r0.last)
  `ISODIR_CHECK_IMPL(a_single_is_last, clk, rst, push.valid0 && !push.valid1,
    push.r0.last)

endmodule

/* test/isodir_entry_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Directory entry checker
// Watches the configuration, byte and result channels of the directory
// record scanner, walks each accepted byte through its own copy of the scan
// state, queues the entries and scan-ended markers that byte must produce,
// and compares every accepted result against the oldest queued one.
// ---------------------------------------------------------------------------
module isodir_entry_checker #(
  parameter int SECTOR = isodir_pkg::SECTOR_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [isodir_pkg::DIR_SIZE_W-1:0] cfg_data,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,
  input  logic                              s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [isodir_pkg::DATA_OUT_W-1:0] m_axis_tdata,
  input  logic [1:0]                        m_axis_tuser,
  input  logic                              m_axis_tlast,
  output int                                fail_count,
  output int                                pending,
  output int                                results_seen
);
  import isodir_pkg::*;

  logic [DIR_SIZE_W-1:0]      extent_len;
  logic [OFFSET_BITS_DEF-1:0] walk_offset;
  logic [OFFSET_BITS_DEF-1:0] rec_start;
  logic [7:0]                 rec_len;
  logic [7:0]                 rec_idx;
  logic [31:0]                lba_acc;
  logic [31:0]                bytes_acc;
  logic [7:0]                 flags_seen;
  logic [7:0]                 name_len_seen;
  logic [7:0]                 name_first_seen;
  scan_mode_t                 walk_mode;

  result_t expected_entries[$];
  int      errors;
  int      got_count;

  task automatic walk_directory_byte(input logic [7:0] b, input logic start);
    result_t         found[2];
    int              n;
    int              i;
    longint unsigned o, sz, next, rs, send, noff;
    logic            keep;
    logic            finish;
    n = 0;
    finish = 1'b0;
    if (start) begin
      walk_offset = '0;
      walk_mode = MODE_AWAIT;
    end
    if (walk_mode == MODE_STOP) return;
    o = walk_offset;
    sz = extent_len;

    if (walk_mode == MODE_AWAIT) begin
      if (o >= sz) begin
        walk_mode = MODE_STOP;
        finish = 1'b1;
      end else if (b == 8'd0) begin
        next = (o / SECTOR + 1) * SECTOR;
        if (next >= sz) begin
          walk_mode = MODE_STOP;
          finish = 1'b1;
        end else begin
          walk_mode = MODE_SKIP;
        end
      end else if (o + b > sz) begin
        walk_mode = MODE_STOP;
        finish = 1'b1;
      end else begin
        rec_start = walk_offset;
        rec_len = b;
        rec_idx = '0;
        lba_acc = '0;
        bytes_acc = '0;
        flags_seen = '0;
        name_len_seen = '0;
        name_first_seen = '0;
        walk_mode = MODE_RECORD;
      end
    end

    if (walk_mode == MODE_RECORD) begin
      i = int'(rec_idx);
      if (i >= int'(IDX_LBA_0) && i <= int'(IDX_LBA_3))
        lba_acc = lba_acc | (32'(b) << (8 * (i - int'(IDX_LBA_0))));
      else if (i >= int'(IDX_SIZE_0) && i <= int'(IDX_SIZE_3))
        bytes_acc = bytes_acc | (32'(b) << (8 * (i - int'(IDX_SIZE_0))));
      else if (i == int'(IDX_FLAGS))
        flags_seen = b;
      else if (i == int'(IDX_NAME_LEN))
        name_len_seen = b;
      else if (i == int'(IDX_NAME_0))
        name_first_seen = b;

      if (i + 1 >= int'(rec_len)) begin
        rs = rec_start;
        send = (rs / SECTOR + 1) * SECTOR;
        if (send > sz) send = sz;
        keep = 1'b1;
        if (int'(rec_len) < int'(MIN_RECORD))
          keep = 1'b0;
        else if (rs + rec_len > send ||
                 int'(MIN_RECORD) + int'(name_len_seen) > int'(rec_len))
          keep = 1'b0;
        else if (name_len_seen == 8'd1 && name_first_seen <= 8'd1)
          keep = 1'b0;  // dot and dot-dot
        if (keep) begin
          noff = rs + MIN_RECORD;
          if (noff > 64'hFF_FFFF) noff = 64'hFF_FFFF;
          found[n] = '0;
          found[n].kind = flags_seen[DIR_FLAG_BIT] ? KIND_DIR : KIND_FILE;
          found[n].extent_lba = lba_acc;
          found[n].extent_bytes = bytes_acc;
          found[n].name_offset = noff[NAME_OFF_W-1:0];
          found[n].name_length = name_len_seen;
          n++;
        end
        if (o + 1 >= sz) begin
          walk_mode = MODE_STOP;
          finish = 1'b1;
        end else begin
          walk_mode = MODE_AWAIT;
        end
      end else begin
        rec_idx = 8'(i + 1);
      end
    end

    if (walk_offset != '1) walk_offset = walk_offset + 1'b1;
    if (walk_mode == MODE_SKIP && ((o + 1) % SECTOR) == 0) walk_mode = MODE_AWAIT;

    if (finish) begin
      found[n] = '0;
      found[n].kind = KIND_END;
      n++;
    end
    if (n > 0) found[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) expected_entries.push_back(found[k]);
  endtask

  task automatic check_field(input string what, input logic [31:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      extent_len = '0;
      walk_offset = '0;
      rec_start = '0;
      rec_len = '0;
      rec_idx = '0;
      lba_acc = '0;
      bytes_acc = '0;
      flags_seen = '0;
      name_len_seen = '0;
      name_first_seen = '0;
      walk_mode = MODE_AWAIT;
      expected_entries.delete();
      errors = 0;
      got_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) extent_len = cfg_data;
      if (s_axis_tvalid && s_axis_tready) walk_directory_byte(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) begin
        got_count++;
        if (expected_entries.size() == 0) begin
          $display("%0t: result mismatch: expected none, actual kind %0d lba 0x%0h",
                   $time, m_axis_tuser, m_axis_tdata[31:0]);
          errors++;
        end else begin
          want = expected_entries.pop_front();
          check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
          check_field("extent_lba", want.extent_lba, m_axis_tdata[31:0]);
          check_field("extent_bytes", want.extent_bytes, m_axis_tdata[63:32]);
          check_field("name_offset", 32'(want.name_offset), 32'(m_axis_tdata[87:64]));
          check_field("name_length", 32'(want.name_length), 32'(m_axis_tdata[95:88]));
          check_field("last", 32'(want.last), 32'(m_axis_tlast));
        end
      end
    end
    fail_count   <= errors;
    pending      <= expected_entries.size();
    results_seen <= got_count;
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Directory record scanner testbench
// Feeds directory extents byte by byte, first directed corner cases, then
// random extents built from well-formed records mixed with broken records
// and raw noise, under random idle cycles on both streams. The checker
// beside the scanner predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module testbench;
  import isodir_pkg::*;

  localparam int SECTOR = SECTOR_BYTES_DEF;
  localparam int SETTLE = 8;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [DIR_SIZE_W-1:0] cfg_data      = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [DATA_OUT_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  int          fail_count;
  int          pending;
  int          results_seen;
  bit          calm = 1'b0;
  int unsigned bytes_sent = 0;
  logic [7:0]  extent_q[$];

  iso9660_directory_record_scanner u_top (.*);

  isodir_entry_checker u_checker (.*);

  always #10 clk = ~clk;

  always @(posedge clk) m_axis_tready <= calm || ($urandom_range(0, 99) >= 24);

  initial begin
    #(10_000_000);
    $display("testbench: FAIL");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic start);
    while (!calm && $urandom_range(0, 99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= start;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // hold input until every queued result is out, then let the pipe settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_dir_size(input logic [DIR_SIZE_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_record(input int len, input logic [7:0] nlen, flags, first,
                             input logic [31:0] lba, size);
    logic [7:0] v;
    for (int i = 0; i < len; i++) begin
      v = $urandom;
      if (i == 0)
        v = 8'(len);
      else if (i >= int'(IDX_LBA_0) && i <= int'(IDX_LBA_3))
        v = lba[8*(i - int'(IDX_LBA_0)) +: 8];
      else if (i >= int'(IDX_SIZE_0) && i <= int'(IDX_SIZE_3))
        v = size[8*(i - int'(IDX_SIZE_0)) +: 8];
      else if (i == int'(IDX_FLAGS))
        v = flags;
      else if (i == int'(IDX_NAME_LEN))
        v = nlen;
      else if (i == int'(IDX_NAME_0))
        v = first;
      extent_q.push_back(v);
    end
  endtask

  task automatic send_extent();
    foreach (extent_q[k]) send_byte(extent_q[k], k == 0);
  endtask

  task automatic build_random_extent(output logic [DIR_SIZE_W-1:0] size);
    int         nsec, room, used, len, nl, pick, n, sz;
    logic [7:0] flags, first;
    nsec = ($urandom_range(0, 9) == 0) ? 2 : 1;
    extent_q.delete();
    for (int s = 0; s < nsec; s++) begin
      room = (s == nsec - 1) ? $urandom_range(40, 400) : SECTOR;
      forever begin
        nl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 222) : $urandom_range(1, 12);
        len = 33 + nl + $urandom_range(0, 3);
        if (len > 255) len = 255;
        flags = $urandom;
        first = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          len = $urandom_range(1, 32);
        end else if (pick < 10) begin
          nl = $urandom_range(len - 32, 255);  // name runs past the record
        end else if (pick < 16) begin
          nl = 1;
          first = $urandom_range(0, 1);
          len = 34 + $urandom_range(0, 3);
        end
        used = extent_q.size() - s * SECTOR;
        if (used + len > room) break;
        push_record(len, 8'(nl), flags, first, $urandom, $urandom);
      end
      if (s < nsec - 1) begin
        if ($urandom_range(0, 1)) begin
          // let the record that did not fit cross the sector boundary
          push_record(len, 8'(nl), flags, first, $urandom, $urandom);
        end else if (extent_q.size() < (s + 1) * SECTOR) begin
          extent_q.push_back(8'h00);
          while (extent_q.size() < (s + 1) * SECTOR) extent_q.push_back($urandom);
        end
      end
    end

    n = extent_q.size();
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      size = '1;
    end else if (pick < 20 && n > 0) begin
      sz = n - $urandom_range(1, (n < 40) ? n : 40);
      size = sz[DIR_SIZE_W-1:0];
    end else if (pick < 35) begin
      sz = n + $urandom_range(1, 100);
      size = sz[DIR_SIZE_W-1:0];
      if ($urandom_range(0, 9) < 7) extent_q.push_back(8'h00);
    end else begin
      size = n[DIR_SIZE_W-1:0];
    end
    repeat ($urandom_range(0, 3)) extent_q.push_back($urandom);
  endtask

  initial begin
    logic [DIR_SIZE_W-1:0] size;
    int                    iter;
    int unsigned           base_bytes;
    int                    base_results;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // no start after reset, dir_size still zero: first byte ends the scan
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);

    // empty extent
    write_dir_size('0);
    send_byte(8'h22, 1'b1);
    send_byte(8'h22, 1'b0);

    // record closing exactly at the extent end: entry then scan-ended
    write_dir_size(24'd34);
    extent_q.delete();
    push_record(34, 8'd1, 8'h00, 8'h41, $urandom, $urandom);
    send_extent();
    send_byte($urandom, 1'b0);

    // largest extent: extreme field values, dot entries, broken records
    write_dir_size('1);
    extent_q.delete();
    push_record(255, 8'd222, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_record(33, 8'd0, 8'h00, 8'h00, 32'h0, 32'h0);
    push_record(34, 8'd1, 8'h02, 8'h00, $urandom, $urandom);
    push_record(34, 8'd1, 8'h02, 8'h01, $urandom, $urandom);
    push_record(1, 8'd0, 8'h00, 8'h00, $urandom, $urandom);
    push_record(32, 8'd0, 8'h00, 8'h00, $urandom, $urandom);
    push_record(40, 8'd8, 8'h00, 8'h41, $urandom, $urandom);
    push_record(36, 8'd3, 8'hFD, 8'h02, $urandom, $urandom);
    send_extent();

    // restart in the middle of a record, then a record that passes the end
    write_dir_size(24'd200);
    extent_q.delete();
    push_record(60, 8'd10, 8'h02, 8'h43, $urandom, $urandom);
    for (int k = 0; k < 20; k++) send_byte(extent_q[k], k == 0);
    extent_q.delete();
    push_record(34, 8'd1, 8'h00, 8'h42, $urandom, $urandom);
    extent_q.push_back(8'hFF);
    send_extent();

    // lower dir_size below the offset while awaiting a length byte
    write_dir_size(24'd300);
    extent_q.delete();
    push_record(40, 8'd5, 8'h02, 8'h44, $urandom, $urandom);
    send_extent();
    write_dir_size(24'd10);
    send_byte(8'h30, 1'b0);
    send_byte(8'h00, 1'b0);

    // three sectors: exact fill, a crossing record, zero byte at the end
    write_dir_size(24'd6144);
    extent_q.delete();
    for (int k = 0; k < 8; k++) push_record(250, 8'd20, $urandom, 8'h41, $urandom, $urandom);
    push_record(48, 8'd15, 8'h00, 8'h45, $urandom, $urandom);
    for (int k = 0; k < 8; k++) push_record(250, 8'd20, $urandom, 8'h46, $urandom, $urandom);
    push_record(60, 8'd10, 8'h02, 8'h47, $urandom, $urandom);
    push_record(40, 8'd7, 8'h00, 8'h48, $urandom, $urandom);
    extent_q.push_back(8'h00);
    send_extent();

    iter = 0;
    base_bytes = bytes_sent;
    base_results = results_seen;
    while (iter < 12 || bytes_sent - base_bytes < 1200 || results_seen - base_results < 60) begin
      calm = (iter >= 15 && iter < 30);
      if ($urandom_range(0, 99) < 12) begin
        write_dir_size($urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom);
        repeat ($urandom_range(5, 60)) send_byte($urandom, $urandom_range(0, 99) < 5);
      end else begin
        build_random_extent(size);
        write_dir_size(size);
        send_extent();
      end
      iter++;
    end
    calm = 1'b0;

    wait_drained();
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/isodir_pkg.sv
sv/isodir_outq.sv
sv/isodir_core.sv
sv/iso9660_directory_record_scanner.sv
test/isodir_entry_checker.sv
test/testbench.sv
